[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the base64 stream encoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define B64SE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64se assertion failed");

// next-cycle implication, disabled while in reset
`define B64SE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64se assertion failed");

`endif

[rtl/core/b64se_pkg.sv]
// Package for the base64 stream encoder: request type, queue sizing,
// phase codes and the alphabet lookup. No dependencies.
package b64se_pkg;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR = 7'h3D;
    localparam logic [5:0] SIX_MASK = 6'h3F;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2,
        PH_BAD   = 2'd3
    } t_phase;

    // one request: up to four characters from one input byte
    typedef struct packed {
        logic [3:0][5:0] sym;
        logic [3:0]      pad;
        logic [1:0]      last_idx;
        logic            eom;
    } t_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] r;
        if (v < 6'd26)
            r = 7'h41 + {1'b0, v};
        else if (v < 6'd52)
            r = 7'h61 + {1'b0, v} - 7'd26;
        else if (v < 6'd62)
            r = 7'h30 + {1'b0, v} - 7'd52;
        else if (v == 6'd62)
            r = 7'h2B;
        else
            r = 7'h2F;
        return r;
    endfunction

endpackage

[rtl/core/b64se_front.sv]
// Front end of the base64 encoder: holds the group phase and carry bits,
// turns each accepted byte into one request. Depends on b64se_pkg.
module b64se_front import b64se_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eom,
    output t_req       o_req
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;

    // next phase and carry
    always_comb begin
        n_phase = r_phase;
        n_carry = r_carry;
        case (r_phase)
            PH_ONE: begin
                if (i_eom) begin
                    n_phase = PH_START;
                    n_carry = 4'd0;
                end else begin
                    n_phase = PH_TWO;
                    n_carry = i_byte[3:0];
                end
            end
            PH_TWO: begin
                n_phase = PH_START;
                n_carry = 4'd0;
            end
            default: begin
                if (i_eom) begin
                    n_phase = PH_START;
                    n_carry = 4'd0;
                end else begin
                    n_phase = PH_ONE;
                    n_carry = {2'b00, i_byte[1:0]};
                end
            end
        endcase
    end

    // request for the current byte
    always_comb begin
        o_req     = '0;
        o_req.eom = i_eom;
        case (r_phase)
            PH_ONE: begin
                o_req.sym[0] = {r_carry[1:0], i_byte[7:4]};
                if (i_eom) begin
                    o_req.sym[1]    = {i_byte[3:0], 2'b00};
                    o_req.pad[2]    = 1'b1;
                    o_req.last_idx  = 2'd2;
                end else begin
                    o_req.last_idx  = 2'd0;
                end
            end
            PH_TWO: begin
                o_req.sym[0]   = {r_carry, i_byte[7:6]};
                o_req.sym[1]   = i_byte[5:0] & SIX_MASK;
                o_req.last_idx = 2'd1;
            end
            default: begin
                // start of group; an unreachable phase drops its carry the same way
                o_req.sym[0] = i_byte[7:2];
                if (i_eom) begin
                    o_req.sym[1]   = {i_byte[1:0], 4'b0000};
                    o_req.pad[2]   = 1'b1;
                    o_req.pad[3]   = 1'b1;
                    o_req.last_idx = 2'd3;
                end else begin
                    o_req.last_idx = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_carry <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

[rtl/core/b64se_fifo.sv]
// Short request queue between front and back end of the encoder.
// Depends on b64se_pkg for the request type and depth.
module b64se_fifo import b64se_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_req       i_data,
    input  logic       i_pop,
    output t_req       o_data,
    output t_fifo_stat o_stat
);

    t_req                r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr, n_wr;
    logic [FQ_PTR_W-1:0] r_rd, n_rd;
    logic [FQ_CNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [FQ_PTR_W-1:0] ptr_inc(input logic [FQ_PTR_W-1:0] p);
        logic [FQ_PTR_W-1:0] r;
        if (p == FQ_PTR_W'(FQ_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd  = i_pop  ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop)
            n_cnt = r_cnt + 1'b1;
        else if (!i_push && i_pop)
            n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/core/b64se_back.sv]
// Back end of the encoder: walks the head request one character per cycle
// into the output register when it is empty or read. Depends on b64se_pkg.
module b64se_back import b64se_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  t_fifo_stat i_stat,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [6:0] o_char,
    output logic       o_last
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [6:0] r_char, n_char;
    logic       r_last, n_last;
    logic       w_load;
    logic       w_end;

    assign w_load = !i_stat.empty && (!r_valid || i_ready);
    assign w_end  = (r_idx == i_req.last_idx);
    assign o_pop  = w_load && w_end;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_last  = r_last;
        if (w_load) begin
            n_valid = 1'b1;
            n_char  = i_req.pad[r_idx] ? PAD_CHAR : b64_char(i_req.sym[r_idx]);
            n_last  = i_req.eom && w_end;
            n_idx   = w_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

[rtl/core/base64_stream_encoder_unit.sv]
// Top level of the base64 stream encoder (standard alphabet, '=' padding).
// Depends on b64se_pkg, b64se_front, b64se_fifo, b64se_back, assert_macros.svh.
//
// Bytes come in on the slave stream with tlast on the final byte of a message;
// ASCII characters go out on the master stream, tlast on the final character.
// A byte is taken whenever the two-entry request queue has room; the back end
// sends one character per cycle while the sink is ready, so a byte gives 1 or 2
// characters mid-stream and up to 4 on a final byte. The single character per
// cycle of the back end sets the sustained rate, near 4 chars per 3 bytes, with
// bursts of up to two bytes absorbed by the queue. An empty message gives no
// output. A byte is registered in the queue before its first char is output.
`include "assert_macros.svh"

module base64_stream_encoder_unit import b64se_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast    // last_char
);

    t_req       w_req_in;
    t_req       w_req_out;
    t_fifo_stat w_stat;
    logic       w_push;
    logic       w_pop;
    logic [6:0] w_char;

    assign s_axis_tready = !w_stat.full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    b64se_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_push),
        .i_byte   (s_axis_tdata),
        .i_eom    (s_axis_tlast),
        .o_req    (w_req_in)
    );

    b64se_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_req_in),
        .i_pop   (w_pop),
        .o_data  (w_req_out),
        .o_stat  (w_stat)
    );

    b64se_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_out),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_char  (w_char),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

    `B64SE_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_push, !w_stat.full)
    `B64SE_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_stat.empty)
    `B64SE_ASSERT_NXT(a_pop_loads_out, i_clk, i_rst_n, w_pop, m_axis_tvalid)

endmodule

[tb/testbench.sv]
// Testbench for base64_stream_encoder_unit: random and directed messages in, checked
// ASCII characters out, with an own encoder prediction. Depends on b64se_pkg and the RTL.
module testbench import b64se_pkg::*;;

    localparam int DIRECTED_BYTES = 22;
    localparam int RANDOM_BYTES   = 138;
    localparam int TAIL_BYTES     = 30;
    localparam int STUCK_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0] data;
        logic       eom;
        bit         drain_first;   // hold until every expected char has come out
        bit         no_idle;
    } t_msg_byte;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_exp_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;    // end_of_message
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] out_char, [7] zero
    logic       m_axis_tlast;           // last_char

    t_msg_byte  pending_bytes[$];
    t_exp_char  expected_chars[$];
    int         byte_total = 0;
    int         bytes_taken = 0;
    int         error_count = 0;
    int         stuck_cycles = 0;
    logic       in_fire = 1'b0;

    // encoder prediction state
    logic [3:0] pred_carry = 4'd0;
    t_phase     pred_phase = PH_START;

    // driver pacing
    int         send_gap = 0;
    int         recv_gap = 0;
    int         seg_left = 0;
    int         idle_pct = 0;
    bit         tail_mode = 1'b0;

    base64_stream_encoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [6:0] sextet_ascii(input logic [5:0] v);
        logic [7:0] c;
        c = B64_ALPHABET[8*(63 - int'(v)) +: 8];
        return c[6:0];
    endfunction

    // expected characters for one accepted byte
    task automatic predict_chars(input logic [7:0] b, input logic eom);
        logic [6:0] ch[4];
        int n;
        t_exp_char e;
        n = 0;
        case (pred_phase)
            PH_ONE: begin
                ch[0] = sextet_ascii({pred_carry[1:0], b[7:4]});
                n = 1;
                pred_carry = b[3:0];
                pred_phase = PH_TWO;
            end
            PH_TWO: begin
                ch[0] = sextet_ascii({pred_carry, b[7:6]});
                ch[1] = sextet_ascii(b[5:0]);
                n = 2;
                pred_carry = 4'd0;
                pred_phase = PH_START;
            end
            default: begin
                ch[0] = sextet_ascii(b[7:2]);
                n = 1;
                pred_carry = {2'b00, b[1:0]};
                pred_phase = PH_ONE;
            end
        endcase
        if (eom) begin
            if (pred_phase == PH_ONE) begin
                ch[n] = sextet_ascii({pred_carry[1:0], 4'b0000});
                ch[n+1] = PAD_CHAR;
                ch[n+2] = PAD_CHAR;
                n = n + 3;
            end else if (pred_phase == PH_TWO) begin
                ch[n] = sextet_ascii({pred_carry, 2'b00});
                ch[n+1] = PAD_CHAR;
                n = n + 2;
            end
            pred_carry = 4'd0;
            pred_phase = PH_START;
        end
        for (int k = 0; k < n; k++) begin
            e.ch = ch[k];
            e.last = eom && (k == n - 1);
            expected_chars.insert(expected_chars.size(), e);
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eom, input bit drain);
        t_msg_byte m;
        m.data = b;
        m.eom = eom;
        m.drain_first = drain;
        m.no_idle = (byte_total >= DIRECTED_BYTES + RANDOM_BYTES - TAIL_BYTES);
        pending_bytes.insert(pending_bytes.size(), m);
        byte_total++;
    endtask

    // monitor: checks output chars, predicts on accepted bytes
    always @(posedge i_clk) begin
        t_exp_char e;
        bit any_fire;
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            any_fire = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                any_fire = 1'b1;
                if (expected_chars.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected char: tdata %h last %b", m_axis_tdata,
                                 m_axis_tlast);
                end else begin
                    e = expected_chars.pop_front();
                    if (m_axis_tdata !== {1'b0, e.ch} || m_axis_tlast !== e.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: expected tdata %h last %b, got %h last %b",
                                     {1'b0, e.ch}, e.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                any_fire = 1'b1;
                predict_chars(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
            stuck_cycles = any_fire ? 0 : stuck_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // driver: byte stream from the pending queue, random stalls on both sides
    always @(negedge i_clk) begin
        logic       v;
        logic [7:0] d;
        logic       l;
        logic       r;
        v = s_axis_tvalid;
        d = s_axis_tdata;
        l = s_axis_tlast;
        r = m_axis_tready;
        if (i_rst_n) begin
            if (in_fire) begin
                pending_bytes.delete(0);
                v = 1'b0;
            end
            // stretches of different idle density, some with none at all
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end else begin
                seg_left--;
            end
            if (!v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() > 0) begin
                    if (pending_bytes[0].drain_first && expected_chars.size() != 0) begin
                        v = 1'b0;
                    end else if (!pending_bytes[0].no_idle &&
                                 $urandom_range(0, 99) < idle_pct) begin
                        send_gap = $urandom_range(1, 14) - 1;
                    end else begin
                        v = 1'b1;
                        d = pending_bytes[0].data;
                        l = pending_bytes[0].eom;
                        tail_mode = pending_bytes[0].no_idle;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                r = 1'b0;
            end else if (!tail_mode && $urandom_range(0, 99) < idle_pct) begin
                recv_gap = $urandom_range(1, 14) - 1;
                r = 1'b0;
            end else begin
                r = 1'b1;
            end
        end
        s_axis_tvalid <= v;
        s_axis_tdata <= d;
        s_axis_tlast <= l;
        m_axis_tready <= r;
    end

    initial begin
        logic [7:0] dir_bytes[DIRECTED_BYTES];
        int dir_lens[8];
        int idx;
        int len;
        bit drain;
        // all-zero and all-one bytes in every group position, '+' and '/' codes,
        // and each padding case (one, two and no pad chars)
        dir_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                      8'hFF, 8'hFB, 8'hFF, 8'hBF, 8'h14, 8'hFB, 8'h9C, 8'h03, 8'h4D,
                      8'h61, 8'h6E, 8'h20, 8'h42};
        dir_lens = '{1, 1, 2, 3, 3, 3, 4, 5};
        idx = 0;
        foreach (dir_lens[m]) begin
            for (int k = 0; k < dir_lens[m]; k++) begin
                add_byte(dir_bytes[idx], k == dir_lens[m] - 1, 1'b0);
                idx++;
            end
        end
        // random messages, mostly short; drain pause before the first one
        drain = 1'b1;
        while (byte_total < DIRECTED_BYTES + RANDOM_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            if (len > DIRECTED_BYTES + RANDOM_BYTES - byte_total)
                len = DIRECTED_BYTES + RANDOM_BYTES - byte_total;
            for (int k = 0; k < len; k++) begin
                add_byte(8'($urandom_range(0, 255)), k == len - 1, drain && k == 0);
            end
            drain = (byte_total < DIRECTED_BYTES + RANDOM_BYTES - TAIL_BYTES) &&
                    ($urandom_range(0, 19) == 0);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != byte_total) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            error_count++;
            $display("%0d expected chars never came out", expected_chars.size());
        end
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[base64_stream_encoder_unit.f]
+incdir+rtl/core
rtl/core/b64se_pkg.sv
rtl/core/b64se_front.sv
rtl/core/b64se_fifo.sv
rtl/core/b64se_back.sv
rtl/core/base64_stream_encoder_unit.sv
tb/testbench.sv
